FILE: src/ninep_pkg.sv
// shared types, constants and the decode program for the 9p message parser
package ninep_pkg;

  localparam int unsigned MaxWalkElements = 16;
  localparam int unsigned CountBits       = 32;
  localparam int unsigned ProgLen         = 60;

  typedef enum logic [1:0] {
    EV_FIELD   = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_ACCEPT  = 2'd2,
    EV_REJECT  = 2'd3
  } event_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_SIZE     = 3'd2,
    ERR_TYPE     = 3'd3,
    ERR_TRUNC    = 3'd4,
    ERR_WALK     = 3'd5,
    ERR_TRAILING = 3'd6
  } error_e;

  typedef enum logic [2:0] {
    OP_FIX  = 3'd0,
    OP_LEN  = 3'd1,
    OP_CNT  = 3'd2,
    OP_LOOP = 3'd3,
    OP_END  = 3'd4
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [3:0]  width;
    logic [4:0]  code;
    logic [1:0]  arg;
    logic        rep;
  } pop_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  code;
    logic [63:0] value;
    logic [4:0]  elem;
    logic [7:0]  pay;
    logic [2:0]  err;
    logic        last;
  } result_t;

  function automatic pop_t mk(op_kind_e k, int unsigned w, int unsigned c,
                              int unsigned a, int unsigned r);
    pop_t p;
    p.kind  = k;
    p.width = 4'(w);
    p.code  = 5'(c);
    p.arg   = 2'(a);
    p.rep   = 1'(r);
    return p;
  endfunction

  function automatic pop_t prog(logic [5:0] ph);
    pop_t p;
    unique case (ph)
      6'd0:  p = mk(OP_FIX, 4, 0, 0, 0);
      6'd1:  p = mk(OP_FIX, 1, 1, 0, 0);
      6'd2:  p = mk(OP_FIX, 2, 2, 0, 0);
      6'd3:  p = mk(OP_END, 0, 0, 0, 0);
      6'd4:  p = mk(OP_FIX, 4, 3, 0, 0);
      6'd5:  p = mk(OP_LEN, 2, 4, 0, 0);
      6'd6:  p = mk(OP_END, 0, 0, 0, 0);
      6'd7:  p = mk(OP_FIX, 4, 13, 0, 0);
      6'd8:  p = mk(OP_FIX, 4, 5, 0, 0);
      6'd9:  p = mk(OP_LEN, 2, 6, 0, 0);
      6'd10: p = mk(OP_LEN, 2, 7, 0, 0);
      6'd11: p = mk(OP_END, 0, 0, 0, 0);
      6'd12: p = mk(OP_FIX, 1, 8, 0, 0);
      6'd13: p = mk(OP_FIX, 4, 9, 0, 0);
      6'd14: p = mk(OP_FIX, 8, 10, 0, 0);
      6'd15: p = mk(OP_END, 0, 0, 0, 0);
      6'd16: p = mk(OP_LEN, 2, 11, 0, 0);
      6'd17: p = mk(OP_END, 0, 0, 0, 0);
      6'd18: p = mk(OP_FIX, 2, 12, 0, 0);
      6'd19: p = mk(OP_END, 0, 0, 0, 0);
      6'd20: p = mk(OP_FIX, 4, 13, 0, 0);
      6'd21: p = mk(OP_FIX, 4, 14, 0, 0);
      6'd22: p = mk(OP_CNT, 2, 15, 1, 0);
      6'd23: p = mk(OP_LEN, 2, 16, 0, 1);
      6'd24: p = mk(OP_LOOP, 0, 0, 1, 0);
      6'd25: p = mk(OP_END, 0, 0, 0, 0);
      6'd26: p = mk(OP_CNT, 2, 17, 3, 0);
      6'd27: p = mk(OP_FIX, 1, 8, 0, 1);
      6'd28: p = mk(OP_FIX, 4, 9, 0, 1);
      6'd29: p = mk(OP_FIX, 8, 10, 0, 1);
      6'd30: p = mk(OP_LOOP, 0, 0, 3, 0);
      6'd31: p = mk(OP_END, 0, 0, 0, 0);
      6'd32: p = mk(OP_FIX, 4, 13, 0, 0);
      6'd33: p = mk(OP_FIX, 1, 18, 0, 0);
      6'd34: p = mk(OP_END, 0, 0, 0, 0);
      6'd35: p = mk(OP_FIX, 1, 8, 0, 0);
      6'd36: p = mk(OP_FIX, 4, 9, 0, 0);
      6'd37: p = mk(OP_FIX, 8, 10, 0, 0);
      6'd38: p = mk(OP_FIX, 4, 19, 0, 0);
      6'd39: p = mk(OP_END, 0, 0, 0, 0);
      6'd40: p = mk(OP_FIX, 4, 13, 0, 0);
      6'd41: p = mk(OP_LEN, 2, 20, 0, 0);
      6'd42: p = mk(OP_FIX, 4, 21, 0, 0);
      6'd43: p = mk(OP_FIX, 1, 18, 0, 0);
      6'd44: p = mk(OP_END, 0, 0, 0, 0);
      6'd45: p = mk(OP_FIX, 4, 13, 0, 0);
      6'd46: p = mk(OP_FIX, 8, 22, 0, 0);
      6'd47: p = mk(OP_FIX, 4, 23, 0, 0);
      6'd48: p = mk(OP_END, 0, 0, 0, 0);
      6'd49: p = mk(OP_FIX, 4, 13, 0, 0);
      6'd50: p = mk(OP_FIX, 8, 22, 0, 0);
      6'd51: p = mk(OP_LEN, 4, 24, 0, 0);
      6'd52: p = mk(OP_END, 0, 0, 0, 0);
      6'd53: p = mk(OP_FIX, 4, 23, 0, 0);
      6'd54: p = mk(OP_END, 0, 0, 0, 0);
      6'd55: p = mk(OP_FIX, 4, 13, 0, 0);
      6'd56: p = mk(OP_END, 0, 0, 0, 0);
      6'd57: p = mk(OP_FIX, 4, 13, 0, 0);
      6'd58: p = mk(OP_LEN, 2, 25, 0, 0);
      6'd59: p = mk(OP_END, 0, 0, 0, 0);
      default: p = mk(OP_END, 0, 0, 0, 0);
    endcase
    return p;
  endfunction

  // start phase for a message type, 0 when the type is not handled
  function automatic logic [5:0] type_start(logic [7:0] t);
    logic [5:0] s;
    unique case (t)
      8'd100, 8'd101: s = 6'd4;
      8'd102:         s = 6'd8;
      8'd103, 8'd105: s = 6'd12;
      8'd104:         s = 6'd7;
      8'd107:         s = 6'd16;
      8'd108:         s = 6'd18;
      8'd109, 8'd121, 8'd123, 8'd127: s = 6'd3;
      8'd110:         s = 6'd20;
      8'd111:         s = 6'd26;
      8'd112:         s = 6'd32;
      8'd113, 8'd115: s = 6'd35;
      8'd114:         s = 6'd40;
      8'd116:         s = 6'd45;
      8'd117:         s = 6'd51;
      8'd118:         s = 6'd49;
      8'd119:         s = 6'd53;
      8'd120, 8'd122, 8'd124: s = 6'd55;
      8'd125:         s = 6'd58;
      8'd126:         s = 6'd57;
      default:        s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: src/ninep_out_buf.sv
// four-entry result buffer between the parser and the output channel
module ninep_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_n_i,
  input  ninep_pkg::result_t push_a_i,
  input  ninep_pkg::result_t push_b_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               ready_i,
  output ninep_pkg::result_t head_o
);

  logic [2:0]         cnt_q, cnt_d;
  logic [1:0]         rd_q, rd_d;
  logic [1:0]         wr_q, wr_d;
  ninep_pkg::result_t mem_q [4];
  logic               pop;
  logic [1:0]         wr1;

  assign valid_o = (cnt_q != 3'd0);
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o & ready_i;
  // room for a full step of two results
  assign space_o = (cnt_q <= 3'd2);
  assign wr1     = wr_q + 2'd1;

  always_comb begin
    rd_d  = rd_q + {1'b0, pop};
    wr_d  = wr_q + push_n_i;
    cnt_d = cnt_q + {1'b0, push_n_i} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
      wr_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q] <= push_a_i;
    if (push_n_i == 2'd2) mem_q[wr1] <= push_b_i;
  end

endmodule

FILE: src/ninep_message_parser.sv
// top level of the 9p message parser: byte decoder and result buffer
//
//  channel | direction | words
//  in      | input     | data_byte, last_byte
//  out     | output    | event_kind .. message_end, up to two per input word
//
// one input word per cycle while the buffer has room; the decoder settles each
// byte combinationally by table lookup and little-endian assembly. results sit
// in a four-entry buffer, and input is taken while at most two results are
// pending. reset returns the parser to the size field of a new message; stalls
// on the output only stop input once the buffer cannot take a full step.
module ninep_message_parser #(
  parameter int unsigned MAX_WALK_ELEMENTS = ninep_pkg::MaxWalkElements,
  parameter int unsigned COUNT_BITS        = ninep_pkg::CountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [4:0]  field_code_o,
  output logic [63:0] field_value_o,
  output logic [4:0]  element_index_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  error_code_o,
  output logic        message_end_o
);

  logic [COUNT_BITS-1:0] byte_count_q, byte_count_d;
  logic [31:0]           declared_size_q, declared_size_d;
  logic [7:0]            message_type_q, message_type_d;
  logic [5:0]            phase_q, phase_d;
  logic [3:0]            fbi_q, fbi_d;
  logic [63:0]           acc_q, acc_d;
  logic [31:0]           pay_rem_q, pay_rem_d;
  logic [4:0]            elem_rem_q, elem_rem_d;
  logic [4:0]            cur_elem_q, cur_elem_d;
  logic [2:0]            err_q, err_d;
  logic                  done_q, done_d;

  logic               take;
  logic               space;
  logic [1:0]         n;
  ninep_pkg::result_t ra, rb, rv, rc;
  ninep_pkg::pop_t    op, op2;
  logic               have_c;
  logic [63:0]        acc_n;
  logic [3:0]         fbi_n;
  logic [4:0]         elem;
  logic [5:0]         nxt, st;
  logic               go;
  logic [2:0]         verdict;
  logic [31:0]        cnt32;

  assign in_ready_o = space;
  assign take       = in_valid_i & space;
  assign cnt32      = 32'(byte_count_q + ((&byte_count_q) ? '0 : COUNT_BITS'(1)));

  always_comb begin
    byte_count_d    = byte_count_q;
    declared_size_d = declared_size_q;
    message_type_d  = message_type_q;
    phase_d         = phase_q;
    fbi_d           = fbi_q;
    acc_d           = acc_q;
    pay_rem_d       = pay_rem_q;
    elem_rem_d      = elem_rem_q;
    cur_elem_d      = cur_elem_q;
    err_d           = err_q;
    done_d          = done_q;
    have_c          = 1'b0;
    rc              = '0;
    go              = 1'b0;
    nxt             = phase_q;
    st              = '0;
    op              = ninep_pkg::prog(phase_q);
    op2             = '0;
    elem            = op.rep ? cur_elem_q : 5'd0;
    fbi_n           = fbi_q + 4'd1;
    acc_n           = acc_q | (64'(data_byte_i) << {fbi_q[2:0], 3'b000});

    if (!(&byte_count_q)) byte_count_d = byte_count_q + COUNT_BITS'(1);

    if (err_q == ninep_pkg::ERR_NONE) begin
      if (done_q) begin
        err_d = ninep_pkg::ERR_TRAILING;
      end else if (op.kind == ninep_pkg::OP_LEN && fbi_q >= op.width) begin
        have_c  = 1'b1;
        rc.kind = ninep_pkg::EV_PAYLOAD;
        rc.code = op.code;
        rc.elem = elem;
        rc.pay  = data_byte_i;
        pay_rem_d = pay_rem_q - 32'd1;
        if (pay_rem_q <= 32'd1) begin
          nxt = phase_q + 6'd1;
          go  = 1'b1;
        end
      end else if (op.kind == ninep_pkg::OP_FIX || op.kind == ninep_pkg::OP_LEN ||
                   op.kind == ninep_pkg::OP_CNT) begin
        acc_d = acc_n;
        fbi_d = fbi_n;
        if (fbi_n >= op.width) begin
          have_c   = 1'b1;
          rc.kind  = ninep_pkg::EV_FIELD;
          rc.code  = op.code;
          rc.value = acc_n;
          rc.elem  = elem;
          if (op.kind == ninep_pkg::OP_FIX) begin
            if (phase_q == 6'd0) declared_size_d = acc_n[31:0];
            if (phase_q == 6'd1) message_type_d = acc_n[7:0];
            if (phase_q == 6'd2) begin
              st = ninep_pkg::type_start(message_type_q);
              if (st == 6'd0) err_d = ninep_pkg::ERR_TYPE;
              else begin
                nxt = st;
                go  = 1'b1;
              end
            end else begin
              nxt = phase_q + 6'd1;
              go  = 1'b1;
            end
          end else if (op.kind == ninep_pkg::OP_LEN) begin
            if (acc_n == 64'd0) begin
              nxt = phase_q + 6'd1;
              go  = 1'b1;
            end else begin
              pay_rem_d = acc_n[31:0];
            end
          end else begin
            if (acc_n > 64'(MAX_WALK_ELEMENTS)) err_d = ninep_pkg::ERR_WALK;
            else if (acc_n == 64'd0) begin
              nxt = phase_q + 6'(op.arg) + 6'd2;
              go  = 1'b1;
            end else begin
              elem_rem_d = acc_n[4:0];
              cur_elem_d = 5'd0;
              nxt = phase_q + 6'd1;
              go  = 1'b1;
            end
          end
        end
      end
    end

    // enter the next phase; loop ops resolve at once (never two in a row)
    if (go) begin
      fbi_d     = '0;
      acc_d     = '0;
      pay_rem_d = '0;
      op2       = ninep_pkg::prog(nxt);
      if (op2.kind == ninep_pkg::OP_LOOP) begin
        if (elem_rem_d != 5'd0) elem_rem_d = elem_rem_d - 5'd1;
        cur_elem_d = cur_elem_d + 5'd1;
        if (elem_rem_d != 5'd0) nxt = nxt - 6'(op2.arg);
        else begin
          nxt    = nxt + 6'd1;
          done_d = 1'b1;
        end
      end else if (op2.kind == ninep_pkg::OP_END) begin
        done_d = 1'b1;
      end
      phase_d = nxt;
    end

    if (cnt32 < 32'd7) verdict = ninep_pkg::ERR_SHORT;
    else if (declared_size_d != cnt32) verdict = ninep_pkg::ERR_SIZE;
    else if (err_d != ninep_pkg::ERR_NONE) verdict = err_d;
    else if (!done_d) verdict = ninep_pkg::ERR_TRUNC;
    else verdict = ninep_pkg::ERR_NONE;

    rv      = '0;
    rv.kind = (verdict == ninep_pkg::ERR_NONE) ? ninep_pkg::EV_ACCEPT
                                               : ninep_pkg::EV_REJECT;
    rv.err  = verdict;
    rv.last = 1'b1;

    if (last_byte_i) begin
      byte_count_d    = '0;
      declared_size_d = '0;
      message_type_d  = '0;
      phase_d         = '0;
      fbi_d           = '0;
      acc_d           = '0;
      pay_rem_d       = '0;
      elem_rem_d      = '0;
      cur_elem_d      = '0;
      err_d           = ninep_pkg::ERR_NONE;
      done_d          = 1'b0;
    end

    ra = have_c ? rc : rv;
    rb = rv;
    n  = take ? ({1'b0, have_c} + {1'b0, last_byte_i}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q    <= '0;
      declared_size_q <= '0;
      message_type_q  <= '0;
      phase_q         <= '0;
      fbi_q           <= '0;
      acc_q           <= '0;
      pay_rem_q       <= '0;
      elem_rem_q      <= '0;
      cur_elem_q      <= '0;
      err_q           <= ninep_pkg::ERR_NONE;
      done_q          <= 1'b0;
    end else if (take) begin
      byte_count_q    <= byte_count_d;
      declared_size_q <= declared_size_d;
      message_type_q  <= message_type_d;
      phase_q         <= phase_d;
      fbi_q           <= fbi_d;
      acc_q           <= acc_d;
      pay_rem_q       <= pay_rem_d;
      elem_rem_q      <= elem_rem_d;
      cur_elem_q      <= cur_elem_d;
      err_q           <= err_d;
      done_q          <= done_d;
    end
  end

  ninep_pkg::result_t head;

  ninep_out_buf u_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (n),
    .push_a_i (ra),
    .push_b_i (rb),
    .space_o  (space),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .head_o   (head)
  );

  assign event_kind_o    = head.kind;
  assign field_code_o    = head.code;
  assign field_value_o   = head.value;
  assign element_index_o = head.elem;
  assign payload_byte_o  = head.pay;
  assign error_code_o    = head.err;
  assign message_end_o   = head.last;

endmodule

FILE: src/ninep_checker.sv
// port checker for the 9p message parser, bound to the top level
module ninep_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] event_kind_o,
  input logic [2:0] error_code_o,
  input logic       message_end_o
);

  // checks that verdict words carry the end flag; other words never set it in the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == ninep_pkg::EV_ACCEPT ||
                    event_kind_o == ninep_pkg::EV_REJECT) |-> message_end_o)
    else $error("verdict without end flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |->
      ((error_code_o == ninep_pkg::ERR_NONE) == (event_kind_o == ninep_pkg::EV_ACCEPT)))
    else $error("verdict kind and error disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // with the output empty the input side is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

endmodule

bind ninep_message_parser ninep_checker u_ninep_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .event_kind_o  (event_kind_o),
  .error_code_o  (error_code_o),
  .message_end_o (message_end_o)
);
